@@ design/vlc_table_decoder_defines.svh @@
// Assertion helpers for the checker file.
`ifndef VLC_TABLE_DECODER_DEFINES_SVH
`define VLC_TABLE_DECODER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define VTD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vlc_table_decoder: check failed");

// Next-cycle implication, masked while reset is asserted.
`define VTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vlc_table_decoder: check failed");

`endif

@@ design/vtd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vtd_pkg;

    localparam int WINDOW_BITS = 32;
    localparam int VALUE_W     = 17;
    localparam int CONSUMED_W  = 6;
    localparam int STATUS_W    = 2;
    localparam int TABLE_W     = 4;

    // leading-zero count holds 0..WINDOW_BITS
    localparam int LZ_W   = $clog2(WINDOW_BITS + 1);
    localparam int LZ_PAD = 1 << LZ_W;
    // prefix + terminator + suffix lengths
    localparam int SUM_W  = $clog2(2 * WINDOW_BITS + 2);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER    = 2'd2;

    localparam logic [TABLE_W-1:0] TBL_PREFIX_FIRST = 4'd0;
    localparam logic [TABLE_W-1:0] TBL_PREFIX_LAST  = 4'd5;
    localparam logic [TABLE_W-1:0] TBL_UNARY_N6     = 4'd6;
    localparam logic [TABLE_W-1:0] TBL_UNARY_N7     = 4'd7;
    localparam logic [TABLE_W-1:0] TBL_TREE         = 4'd8;
    localparam logic [TABLE_W-1:0] TBL_TREE_UNARY   = 4'd9;
    localparam logic [TABLE_W-1:0] TBL_EXP_GOLOMB   = 4'd10;
    localparam logic [TABLE_W-1:0] TBL_PAIRED       = 4'd11;
    localparam logic [TABLE_W-1:0] TBL_TRUNC4       = 4'd12;
    localparam logic [TABLE_W-1:0] TBL_TRUNC6       = 4'd13;

    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_PREFIX     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_UNARY      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TREE       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TREE_UNARY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXP_GOLOMB = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PAIRED     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_TRUNC      = 3'd6;
    localparam logic [KIND_W-1:0] KIND_ILLEGAL    = 3'd7;

    typedef struct packed {
        logic [TABLE_W-1:0]     table_req;
        logic [WINDOW_BITS-1:0] window;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0]    value;
        logic [CONSUMED_W-1:0] consumed;
        logic [STATUS_W-1:0]   status;
    } out_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [TABLE_W-1:0]     table_req;
        logic [WINDOW_BITS-1:0] window;
        logic [LZ_W-1:0]        lz;
    } entry_t;

endpackage

`default_nettype wire

@@ design/vtd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vtd_front (
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire vtd_pkg::in_item_t s_data,
    output logic                   wr_valid,
    input  wire logic              wr_ready,
    output vtd_pkg::entry_t        wr_data
);

    localparam int W    = vtd_pkg::WINDOW_BITS;
    localparam int LZ_W = vtd_pkg::LZ_W;
    localparam int PAD  = vtd_pkg::LZ_PAD;

    // Binary search over a padded word; the padding ones stop an all-zero window at W.
    function automatic logic [LZ_W-1:0] count_lz(input logic [W-1:0] w);
        logic [PAD-1:0]  v;
        logic [LZ_W-1:0] cnt;
        v   = {w, {(PAD - W){1'b1}}};
        cnt = '0;
        for (int j = LZ_W - 1; j >= 0; j--) begin
            if ((v >> (PAD - (1 << j))) == '0) begin
                cnt = cnt | LZ_W'(1 << j);
                v   = v << (1 << j);
            end
        end
        return cnt;
    endfunction

    logic [vtd_pkg::KIND_W-1:0] kind;

    always_comb begin
        case (s_data.table_req)
            vtd_pkg::TBL_UNARY_N6, vtd_pkg::TBL_UNARY_N7: kind = vtd_pkg::KIND_UNARY;
            vtd_pkg::TBL_TREE:                            kind = vtd_pkg::KIND_TREE;
            vtd_pkg::TBL_TREE_UNARY:                      kind = vtd_pkg::KIND_TREE_UNARY;
            vtd_pkg::TBL_EXP_GOLOMB:                      kind = vtd_pkg::KIND_EXP_GOLOMB;
            vtd_pkg::TBL_PAIRED:                          kind = vtd_pkg::KIND_PAIRED;
            vtd_pkg::TBL_TRUNC4, vtd_pkg::TBL_TRUNC6:     kind = vtd_pkg::KIND_TRUNC;
            default: begin
                if (s_data.table_req inside
                        {[vtd_pkg::TBL_PREFIX_FIRST:vtd_pkg::TBL_PREFIX_LAST]}) begin
                    kind = vtd_pkg::KIND_PREFIX;
                end else begin
                    kind = vtd_pkg::KIND_ILLEGAL;
                end
            end
        endcase
    end

    assign wr_data.kind      = kind;
    assign wr_data.table_req = s_data.table_req;
    assign wr_data.window    = s_data.window;
    assign wr_data.lz        = count_lz(s_data.window);
    assign wr_valid          = s_valid;
    assign s_ready           = wr_ready;

endmodule

`default_nettype wire

@@ design/vtd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vtd_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            wr_valid,
    output logic                 wr_ready,
    input  wire vtd_pkg::entry_t wr_data,
    output logic                 rd_valid,
    input  wire logic            rd_ready,
    output vtd_pkg::entry_t      rd_data
);

    localparam int DEPTH = vtd_pkg::QUEUE_DEPTH;
    localparam int AW    = vtd_pkg::QUEUE_AW;
    localparam int CW    = vtd_pkg::QUEUE_CW;

    vtd_pkg::entry_t slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign wr_ready = count_reg != CW'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ design/vtd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vtd_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            rd_valid,
    output logic                 rd_ready,
    input  wire vtd_pkg::entry_t rd_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output vtd_pkg::out_item_t   m_data
);

    localparam int W     = vtd_pkg::WINDOW_BITS;
    localparam int LZ_W  = vtd_pkg::LZ_W;
    localparam int SUM_W = vtd_pkg::SUM_W;
    localparam int VW    = vtd_pkg::VALUE_W;
    localparam int CNW   = vtd_pkg::CONSUMED_W;

    localparam int PREFIX_LIMIT    = 6;
    localparam int PREFIX_MULT     = 5;
    localparam int UNARY_OFFSET    = 4;
    localparam int TREE_UNARY_BITS = 4;
    localparam int TREE_UNARY_BIAS = 11;
    localparam int TREE_LONG_BIAS  = 3;
    localparam int TRUNC_SHORT     = 4;
    localparam int TRUNC_LONG      = 6;

    vtd_pkg::out_item_t out_data_reg;
    logic               out_valid_reg;
    vtd_pkg::out_item_t result;

    logic [LZ_W-1:0]  lz;
    logic [VW-1:0]    lz_v;
    logic [SUM_W-1:0] suffix_len;
    logic [SUM_W-1:0] total_len;
    logic [W-1:0]     aligned;
    logic [W-1:0]     suffix_bits;
    logic [VW-1:0]    suffix_v;
    logic [VW-1:0]    lead_v;
    logic             over_unary;
    logic             b0, b1, b2, b3;
    logic [LZ_W-1:0]  trunc_limit;
    logic [VW-1:0]    value;
    logic [SUM_W-1:0] length;
    logic             over;

    assign lz   = rd_data.lz;
    assign lz_v = VW'(lz);
    assign b0   = rd_data.window[W-1];
    assign b1   = rd_data.window[W-2];
    assign b2   = rd_data.window[W-3];
    assign b3   = rd_data.window[W-4];

    // suffix length after the terminating one
    always_comb begin
        case (rd_data.kind)
            vtd_pkg::KIND_PREFIX: begin
                if (lz < LZ_W'(PREFIX_LIMIT)) begin
                    suffix_len = SUM_W'(rd_data.table_req);
                end else begin
                    suffix_len = SUM_W'(rd_data.table_req) + SUM_W'(lz)
                               - SUM_W'(PREFIX_LIMIT);
                end
            end
            vtd_pkg::KIND_UNARY:      suffix_len = SUM_W'(rd_data.table_req) - SUM_W'(UNARY_OFFSET);
            vtd_pkg::KIND_TREE_UNARY: suffix_len = SUM_W'(TREE_UNARY_BITS);
            vtd_pkg::KIND_EXP_GOLOMB: suffix_len = SUM_W'(lz);
            vtd_pkg::KIND_PAIRED:     suffix_len = SUM_W'(1);
            default:                  suffix_len = '0;
        endcase
    end

    // align the suffix to the top, then drop it to the bottom
    assign aligned     = rd_data.window << (SUM_W'(lz) + SUM_W'(1));
    assign suffix_bits = aligned >> (SUM_W'(W) - suffix_len);
    assign suffix_v    = VW'(suffix_bits);
    assign lead_v      = (suffix_len < SUM_W'(VW)) ? (VW'(1) << suffix_len) : '0;
    assign total_len   = SUM_W'(lz) + SUM_W'(1) + suffix_len;
    assign over_unary  = (lz == LZ_W'(W)) || (total_len > SUM_W'(W));
    assign trunc_limit = (rd_data.table_req == vtd_pkg::TBL_TRUNC4) ? LZ_W'(TRUNC_SHORT)
                                                                    : LZ_W'(TRUNC_LONG);

    always_comb begin
        value  = '0;
        length = total_len;
        over   = 1'b0;
        case (rd_data.kind)
            vtd_pkg::KIND_PREFIX: begin
                over = over_unary;
                if (lz < LZ_W'(PREFIX_LIMIT)) begin
                    value = (lz_v << rd_data.table_req) + suffix_v;
                end else begin
                    // escape: Exp-Golomb tail offset past the short codes
                    value = (VW'(PREFIX_MULT) << rd_data.table_req) + lead_v + suffix_v;
                end
            end
            vtd_pkg::KIND_UNARY: begin
                over  = over_unary;
                value = (lz_v << suffix_len) + suffix_v;
            end
            vtd_pkg::KIND_TREE: begin
                if (b0) begin
                    value  = VW'(0);
                    length = SUM_W'(1);
                end else begin
                    value  = b1 ? VW'(1) : VW'(2);
                    length = SUM_W'(2);
                end
            end
            vtd_pkg::KIND_TREE_UNARY: begin
                if (b0 && b1) begin
                    value  = VW'(rd_data.window[W-3 -: 3]) + VW'(TREE_LONG_BIAS);
                    length = SUM_W'(5);
                end else if (b0 && b2) begin
                    value  = VW'(b3) + VW'(1);
                    length = SUM_W'(4);
                end else if (b0) begin
                    value  = VW'(0);
                    length = SUM_W'(3);
                end else begin
                    over  = over_unary;
                    value = ((lz_v - VW'(1)) << TREE_UNARY_BITS) + suffix_v
                          + VW'(TREE_UNARY_BIAS);
                end
            end
            vtd_pkg::KIND_EXP_GOLOMB: begin
                over  = over_unary;
                value = lead_v + suffix_v - VW'(1);
            end
            vtd_pkg::KIND_PAIRED: begin
                if (b0) begin
                    value  = VW'(0);
                    length = SUM_W'(1);
                end else if (b1) begin
                    value  = VW'(1);
                    length = SUM_W'(2);
                end else begin
                    over  = over_unary;
                    value = ((lz_v - VW'(1)) << 1) + suffix_v;
                end
            end
            vtd_pkg::KIND_TRUNC: begin
                // no terminator once the limit is reached
                if (lz >= trunc_limit) begin
                    value  = VW'(trunc_limit);
                    length = SUM_W'(trunc_limit);
                end else begin
                    value  = lz_v;
                    length = SUM_W'(lz) + SUM_W'(1);
                end
            end
            default: begin
                value  = '0;
                length = '0;
            end
        endcase
    end

    always_comb begin
        if (rd_data.kind == vtd_pkg::KIND_ILLEGAL) begin
            result.value    = '0;
            result.consumed = '0;
            result.status   = vtd_pkg::ST_ILLEGAL;
        end else if (over) begin
            result.value    = '0;
            result.consumed = '0;
            result.status   = vtd_pkg::ST_OVER;
        end else begin
            result.value    = value;
            result.consumed = CNW'(length);
            result.status   = vtd_pkg::ST_OK;
        end
    end

    // advance whenever the output slot is free or being drained
    assign rd_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (rd_valid && rd_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_valid && rd_ready) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

@@ design/vlc_table_decoder.sv @@
// Channel   Dir  Handshake           Beat payload
// s_        in   s_valid / s_ready   vtd_pkg::in_item_t  {table_req, window}
// m_        out  m_valid / m_ready   vtd_pkg::out_item_t {value, consumed, status}
//
// One beat per cycle in and out while m_ready is high. The front counts leading
// zeros and sorts the table, a two-entry queue holds the beats, and the back
// decodes one codeword per cycle into the output register unless it is stalled.
// Up to three beats are in flight; s_ready drops when the queue is full.
// Reset is synchronous on aresetn low and empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module vlc_table_decoder (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire vtd_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output vtd_pkg::out_item_t      m_data
);

    logic            wr_valid, wr_ready;
    vtd_pkg::entry_t wr_data;
    logic            rd_valid, rd_ready;
    vtd_pkg::entry_t rd_data;

    vtd_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_data)
    );

    vtd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_data),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_data  (rd_data)
    );

    vtd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_data  (rd_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

@@ design/vtd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "vlc_table_decoder_defines.svh"

module vtd_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire vtd_pkg::in_item_t  s_data,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire vtd_pkg::out_item_t m_data
);

    localparam int MAX_BEATS = vtd_pkg::QUEUE_DEPTH + 1;
    localparam int OW        = $clog2(MAX_BEATS + 1);

    logic [OW-1:0] inflight_reg, inflight_next;
    logic          in_beat, out_beat;
    logic          bad_zeroed;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    always_comb begin
        inflight_next = inflight_reg;
        if (in_beat && !out_beat) begin
            inflight_next = inflight_reg + OW'(1);
        end else if (out_beat && !in_beat) begin
            inflight_next = inflight_reg - OW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // error results carry zero fields; good results always consume a bit
    assign bad_zeroed = (m_data.status == vtd_pkg::ST_OK)
                      ? (m_data.consumed != '0)
                      : (m_data.value == '0 && m_data.consumed == '0);

    `VTD_ASSERT_IMPLY(a_no_phantom_beat, aclk, aresetn, m_valid, inflight_reg != '0)
    `VTD_ASSERT_IMPLY(a_full_backpressure, aclk, aresetn, inflight_reg == OW'(MAX_BEATS), !s_ready)
    `VTD_ASSERT_IMPLY(a_result_fields, aclk, aresetn, m_valid, bad_zeroed)
    `VTD_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `VTD_ASSERT_NEXT(a_input_holds, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_data))

endmodule

bind vlc_table_decoder vtd_checker u_vtd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
